/* rtl/aar_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aar_pkg: shared types and constants of the axis-angle rotation matrix
// Q30 working type, angle reduction and radian constants, sine and cosine
// series coefficients, and the record that travels down the pipeline.
// ----------------------------------------------------------------------------
package aar_pkg;

  // index of the last payload stage; the output register sits one past it
  localparam int PIPE_LAST = 19;

  typedef logic signed [32:0] q30_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  // angle units are 1/64 degree
  localparam logic signed [16:0] TURN_S        = 17'sd23040;
  localparam logic [14:0]        QUARTER_UNITS = 15'd5760;
  localparam logic [14:0]        HALF_UNITS    = 15'd11520;
  localparam logic [14:0]        THREEQ_UNITS  = 15'd17280;
  localparam logic [12:0]        EIGHTH_UNITS  = 13'd2880;

  // radians in Q30: x = round(u * 3.1415926 * 2^30 / (180 * 64)), split into an
  // exact integer slope and a fraction kept to RAD_SHIFT bits
  localparam logic [63:0] RAD_MUL  = 64'd31415926 << 15;
  localparam logic [63:0] RAD_DIV  = 64'd14400000000 >> 12;
  localparam logic [63:0] RAD_INT  = RAD_MUL / RAD_DIV;
  localparam logic [63:0] RAD_REM  = RAD_MUL % RAD_DIV;
  localparam int          RAD_SHIFT = 36;
  localparam logic [63:0] RAD_FRAC = (RAD_REM << RAD_SHIFT) / RAD_DIV;
  localparam logic [48:0] RAD_HALF = 49'd1 << (RAD_SHIFT - 1);

  localparam q30_t Q30_ONE  = 33'sd1073741824;
  localparam q30_t Q30_HALF = 33'sd536870912;

  localparam q30_t SIN_K9 = 33'sd2959;
  localparam q30_t SIN_K7 = -33'sd213045;
  localparam q30_t SIN_K5 = 33'sd8947849;
  localparam q30_t SIN_K3 = -33'sd178956971;

  localparam q30_t COS_K10 = -33'sd296;
  localparam q30_t COS_K8  = 33'sd26631;
  localparam q30_t COS_K6  = -33'sd1491308;
  localparam q30_t COS_K4  = 33'sd44739243;

  // divider start: |v| * 2^(30+k) with k = 16 + kx, minus the 32 quotient bits
  localparam logic [4:0] DIV_PRE_SHIFT = 5'd14;

  localparam logic signed [18:0] OUT_MAX = 19'sd16384;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [31:0] rad;
  } sqrt_st_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
  } div_st_t;

  typedef struct packed {
    logic [14:0]        ang;
    quad_t              qd;
    logic               swap;
    logic [11:0]        u;
    logic [30:0]        pq;
    logic [47:0]        pf;
    q30_t               x;
    q30_t               x2;
    q30_t               hs;
    q30_t               hc;
    q30_t               s;
    q30_t               c;
    q30_t               t;
    logic [2:0][30:0]   sq;
    logic [2:0][15:0]   mag;
    logic [2:0]         neg;
    logic               zero;
    logic [3:0]         kx;
    sqrt_st_t           sqr;
    logic [31:0]        dvs;
    div_st_t [2:0]      dv;
    q30_t [5:0]         aa;
    q30_t [2:0]         sa;
    q30_t [5:0]         taa;
  } stage_t;

endpackage

/* rtl/axis_angle_rotation_matrix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix: Rodrigues rotation matrix in fixed point
// Takes an angle in 1/64 degree and a Q2.14 axis and returns the nine Q1.14
// entries of cos*I + (1-cos)*a*a^T + sin*[a]x, a being the axis scaled to unit
// length; a zero axis yields cos*I and raises the zero_axis flag in tuser.
// The block takes one beat per clock while the output side does not stall,
// and its pipeline depth is set by the axis normalization: a 32-step square
// root and a 32-step divide, each resolved four steps per pipeline stage.
// A stall on the output holds only the stages that are full, so bubbles close
// up and the input keeps flowing.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // angle, axis_x, axis_y, axis_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // r00, r01, r02, r10, r11, r12, r20, r21, r22
  output logic         out_tuser   // zero_axis
);

  localparam int OUT_STAGE = aar_pkg::PIPE_LAST + 1;

  aar_pkg::stage_t pipe_r   [0:aar_pkg::PIPE_LAST];
  aar_pkg::stage_t pipe_nxt [0:aar_pkg::PIPE_LAST];
  logic [OUT_STAGE:0] vld_r;
  logic [OUT_STAGE:0] en;

  logic [143:0] out_data_r, out_data_nxt;
  logic         out_zero_r;

  // stage helpers
  logic signed [15:0] v_w [3];
  logic signed [31:0] vsq_w [3];
  logic signed [16:0] ang_w, ang_a;
  logic [14:0]        base_w;
  logic [12:0]        rmd_w;
  logic [31:0]        n2_w, m_w;
  logic [3:0]         kx_w;
  logic [46:0]        pre_w;
  logic [48:0]        xf_w;
  logic [31:0]        nlow_w;
  logic [3:0]         nb_w;
  aar_pkg::q30_t      sr_w, cr_w, cq_w;
  aar_pkg::q30_t      a_w [3];
  aar_pkg::q30_t      ov_c, ov_taa [6], ov_sa [3];
  logic signed [34:0] ent_w [9];

  function automatic aar_pkg::q30_t mul30(aar_pkg::q30_t p, aar_pkg::q30_t q);
    logic signed [65:0] prod;
    prod = p * q + (66'sd1 <<< 29);
    return prod[62:30];
  endfunction

  function automatic aar_pkg::sqrt_st_t sqrt_step4(aar_pkg::sqrt_st_t st);
    aar_pkg::sqrt_st_t w;
    logic [34:0]       trial;
    w = st;
    for (int i = 0; i < 4; i++) begin
      w.rem = {w.rem[32:0], w.rad[31:30]};
      trial = {1'b0, w.root, 2'b01};
      if (w.rem >= trial) begin
        w.rem  = w.rem - trial;
        w.root = {w.root[30:0], 1'b1};
      end else begin
        w.root = {w.root[30:0], 1'b0};
      end
      w.rad = {w.rad[29:0], 2'b00};
    end
    return w;
  endfunction

  function automatic aar_pkg::div_st_t div_step4(aar_pkg::div_st_t st, logic [31:0] dvs,
                                                 logic [3:0] nb);
    aar_pkg::div_st_t w;
    logic [32:0]      r;
    w = st;
    for (int i = 3; i >= 0; i--) begin
      r = {w.rem, nb[i]};
      if (r >= {1'b0, dvs}) begin
        r     = r - {1'b0, dvs};
        w.quo = {w.quo[30:0], 1'b1};
      end else begin
        w.quo = {w.quo[30:0], 1'b0};
      end
      w.rem = r[31:0];
    end
    return w;
  endfunction

  function automatic logic [15:0] to_q14(logic signed [34:0] v);
    logic signed [34:0] o;
    o = (v + 35'sd32768) >>> 16;
    if (o > 35'(aar_pkg::OUT_MAX)) begin
      o = 35'(aar_pkg::OUT_MAX);
    end else if (o < -35'(aar_pkg::OUT_MAX)) begin
      o = -35'(aar_pkg::OUT_MAX);
    end
    return o[15:0];
  endfunction

  // a stage advances when it is empty or its successor advances
  always_comb begin
    en[OUT_STAGE] = ~vld_r[OUT_STAGE] | out_tready;
    for (int i = OUT_STAGE - 1; i >= 0; i--) begin
      en[i] = ~vld_r[i] | en[i + 1];
    end
  end

  assign in_tready = en[0];

  always_comb begin
    pipe_nxt[0] = '0;
    for (int i = 1; i <= aar_pkg::PIPE_LAST; i++) begin
      pipe_nxt[i] = pipe_r[i - 1];
    end

    // stage 0: angle wrap, axis squares and magnitudes
    v_w[0] = in_tdata[31:16];
    v_w[1] = in_tdata[47:32];
    v_w[2] = in_tdata[63:48];
    for (int k = 0; k < 3; k++) begin
      vsq_w[k] = v_w[k] * v_w[k];
      pipe_nxt[0].sq[k]  = vsq_w[k][30:0];
      pipe_nxt[0].neg[k] = v_w[k][15];
      pipe_nxt[0].mag[k] = v_w[k][15] ? 16'(-v_w[k]) : v_w[k];
    end
    ang_w = 17'($signed(in_tdata[15:0]));
    if (ang_w < 0) begin
      ang_a = ang_w + aar_pkg::TURN_S;
      if (ang_a < 0) begin
        ang_a = ang_a + aar_pkg::TURN_S;
      end
    end else if (ang_w >= aar_pkg::TURN_S) begin
      ang_a = ang_w - aar_pkg::TURN_S;
    end else begin
      ang_a = ang_w;
    end
    pipe_nxt[0].ang = ang_a[14:0];

    // stage 1: quadrant split, axis length squared and its normalization
    if (pipe_r[0].ang < aar_pkg::QUARTER_UNITS) begin
      pipe_nxt[1].qd = aar_pkg::QUAD_0;
      base_w = '0;
    end else if (pipe_r[0].ang < aar_pkg::HALF_UNITS) begin
      pipe_nxt[1].qd = aar_pkg::QUAD_1;
      base_w = aar_pkg::QUARTER_UNITS;
    end else if (pipe_r[0].ang < aar_pkg::THREEQ_UNITS) begin
      pipe_nxt[1].qd = aar_pkg::QUAD_2;
      base_w = aar_pkg::HALF_UNITS;
    end else begin
      pipe_nxt[1].qd = aar_pkg::QUAD_3;
      base_w = aar_pkg::THREEQ_UNITS;
    end
    rmd_w = 13'(pipe_r[0].ang - base_w);
    pipe_nxt[1].swap = rmd_w > aar_pkg::EIGHTH_UNITS;
    pipe_nxt[1].u = pipe_nxt[1].swap ? 12'(aar_pkg::QUARTER_UNITS[12:0] - rmd_w)
                                     : rmd_w[11:0];

    n2_w = 32'(pipe_r[0].sq[0]) + 32'(pipe_r[0].sq[1]) + 32'(pipe_r[0].sq[2]);
    pipe_nxt[1].zero = (n2_w == '0);
    m_w  = n2_w;
    kx_w = '0;
    if (m_w[31:16] == '0) begin
      m_w  = {m_w[15:0], 16'b0};
      kx_w = kx_w + 4'd8;
    end
    if (m_w[31:24] == '0) begin
      m_w  = {m_w[23:0], 8'b0};
      kx_w = kx_w + 4'd4;
    end
    if (m_w[31:28] == '0) begin
      m_w  = {m_w[27:0], 4'b0};
      kx_w = kx_w + 4'd2;
    end
    if (m_w[31:30] == '0) begin
      m_w  = {m_w[29:0], 2'b0};
      kx_w = kx_w + 4'd1;
    end
    pipe_nxt[1].kx       = kx_w;
    pipe_nxt[1].sqr.rem  = '0;
    pipe_nxt[1].sqr.root = '0;
    pipe_nxt[1].sqr.rad  = m_w;

    // stages 2..9: square root of m * 2^32, four result bits a stage
    for (int i = 2; i <= 9; i++) begin
      pipe_nxt[i].sqr = sqrt_step4(pipe_r[i - 1].sqr);
    end

    // radians in Q30, then the sine and cosine series
    pipe_nxt[2].pq = pipe_r[1].u * aar_pkg::RAD_INT[18:0];
    pipe_nxt[2].pf = pipe_r[1].u * aar_pkg::RAD_FRAC[35:0];
    xf_w = (49'(pipe_r[2].pf) + aar_pkg::RAD_HALF) >> aar_pkg::RAD_SHIFT;
    pipe_nxt[3].x  = $signed({2'b0, pipe_r[2].pq}) + $signed({20'b0, xf_w[12:0]});
    pipe_nxt[4].x2 = mul30(pipe_r[3].x, pipe_r[3].x);
    pipe_nxt[5].hs = aar_pkg::SIN_K7 + mul30(pipe_r[4].x2, aar_pkg::SIN_K9);
    pipe_nxt[5].hc = aar_pkg::COS_K8 + mul30(pipe_r[4].x2, aar_pkg::COS_K10);
    pipe_nxt[6].hs = aar_pkg::SIN_K5 + mul30(pipe_r[5].x2, pipe_r[5].hs);
    pipe_nxt[6].hc = aar_pkg::COS_K6 + mul30(pipe_r[5].x2, pipe_r[5].hc);
    pipe_nxt[7].hs = aar_pkg::SIN_K3 + mul30(pipe_r[6].x2, pipe_r[6].hs);
    pipe_nxt[7].hc = aar_pkg::COS_K4 + mul30(pipe_r[6].x2, pipe_r[6].hc);
    pipe_nxt[8].hs = aar_pkg::Q30_ONE + mul30(pipe_r[7].x2, pipe_r[7].hs);
    pipe_nxt[8].hc = -aar_pkg::Q30_HALF + mul30(pipe_r[7].x2, pipe_r[7].hc);
    pipe_nxt[9].s  = mul30(pipe_r[8].x, pipe_r[8].hs);
    pipe_nxt[9].c  = aar_pkg::Q30_ONE + mul30(pipe_r[8].x2, pipe_r[8].hc);

    // divider start values sit beside the last root stage
    pipe_nxt[9].dvs = pipe_nxt[9].sqr.root;
    for (int k = 0; k < 3; k++) begin
      pre_w = {31'b0, pipe_r[8].mag[k]} << (aar_pkg::DIV_PRE_SHIFT + {1'b0, pipe_r[8].kx});
      pipe_nxt[9].dv[k].rem = pre_w[31:0];
      pipe_nxt[9].dv[k].quo = '0;
    end

    // stage 10: fold the octant and quadrant back
    sr_w = pipe_r[9].swap ? pipe_r[9].c : pipe_r[9].s;
    cr_w = pipe_r[9].swap ? pipe_r[9].s : pipe_r[9].c;
    case (pipe_r[9].qd)
      aar_pkg::QUAD_0: begin
        pipe_nxt[10].s = sr_w;
        cq_w = cr_w;
      end
      aar_pkg::QUAD_1: begin
        pipe_nxt[10].s = cr_w;
        cq_w = -sr_w;
      end
      aar_pkg::QUAD_2: begin
        pipe_nxt[10].s = -sr_w;
        cq_w = -cr_w;
      end
      default: begin
        pipe_nxt[10].s = -cr_w;
        cq_w = sr_w;
      end
    endcase
    pipe_nxt[10].c = cq_w;
    pipe_nxt[10].t = aar_pkg::Q30_ONE - cq_w;

    // stages 10..17: unit components, rounded quotient, four bits a stage
    for (int i = 10; i <= 17; i++) begin
      nlow_w = {1'b0, pipe_r[i - 1].dvs[31:1]};
      nb_w   = nlow_w[31 - 4 * (i - 10) -: 4];
      for (int k = 0; k < 3; k++) begin
        pipe_nxt[i].dv[k] = div_step4(pipe_r[i - 1].dv[k], pipe_r[i - 1].dvs, nb_w);
      end
    end

    // stage 18: signed unit axis and its products
    for (int k = 0; k < 3; k++) begin
      if (pipe_r[17].zero) begin
        a_w[k] = '0;
      end else if (pipe_r[17].neg[k]) begin
        a_w[k] = -$signed({1'b0, pipe_r[17].dv[k].quo});
      end else begin
        a_w[k] = $signed({1'b0, pipe_r[17].dv[k].quo});
      end
      pipe_nxt[18].sa[k] = mul30(pipe_r[17].s, a_w[k]);
    end
    pipe_nxt[18].aa[0] = mul30(a_w[0], a_w[0]);
    pipe_nxt[18].aa[1] = mul30(a_w[1], a_w[1]);
    pipe_nxt[18].aa[2] = mul30(a_w[2], a_w[2]);
    pipe_nxt[18].aa[3] = mul30(a_w[0], a_w[1]);
    pipe_nxt[18].aa[4] = mul30(a_w[0], a_w[2]);
    pipe_nxt[18].aa[5] = mul30(a_w[1], a_w[2]);

    // stage 19: scale by 1 - cos
    for (int j = 0; j < 6; j++) begin
      pipe_nxt[19].taa[j] = mul30(pipe_r[18].t, pipe_r[18].aa[j]);
    end
  end

  // output stage: sums and Q1.14 conversion
  always_comb begin
    ov_c = pipe_r[aar_pkg::PIPE_LAST].c;
    for (int j = 0; j < 6; j++) begin
      ov_taa[j] = pipe_r[aar_pkg::PIPE_LAST].taa[j];
    end
    for (int k = 0; k < 3; k++) begin
      ov_sa[k] = pipe_r[aar_pkg::PIPE_LAST].sa[k];
    end
    ent_w[0] = 35'(ov_c) + 35'(ov_taa[0]);
    ent_w[1] = 35'(ov_taa[3]) - 35'(ov_sa[2]);
    ent_w[2] = 35'(ov_taa[4]) + 35'(ov_sa[1]);
    ent_w[3] = 35'(ov_taa[3]) + 35'(ov_sa[2]);
    ent_w[4] = 35'(ov_c) + 35'(ov_taa[1]);
    ent_w[5] = 35'(ov_taa[5]) - 35'(ov_sa[0]);
    ent_w[6] = 35'(ov_taa[4]) - 35'(ov_sa[1]);
    ent_w[7] = 35'(ov_taa[5]) + 35'(ov_sa[0]);
    ent_w[8] = 35'(ov_c) + 35'(ov_taa[2]);
    for (int e = 0; e < 9; e++) begin
      out_data_nxt[16 * e +: 16] = to_q14(ent_w[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i <= OUT_STAGE; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= aar_pkg::PIPE_LAST; i++) begin
      if (en[i]) begin
        pipe_r[i] <= pipe_nxt[i];
      end
    end
    if (en[OUT_STAGE]) begin
      out_data_r <= out_data_nxt;
      out_zero_r <= pipe_r[aar_pkg::PIPE_LAST].zero;
    end
  end

  assign out_tvalid = vld_r[OUT_STAGE];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

  // zero axis leaves only cos on the diagonal
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[31:16] == '0 && out_tdata[47:32] == '0 && out_tdata[63:48] == '0 &&
      out_tdata[95:80] == '0 && out_tdata[111:96] == '0 && out_tdata[127:112] == '0 &&
      out_tdata[15:0] == out_tdata[79:64] && out_tdata[79:64] == out_tdata[143:128])
    else $error("zero axis result is not a scaled identity");

  // with the output free the whole pipe moves
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while output side is free");

  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

endmodule

/* test/tb_axis_angle_rotation_matrix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_angle_rotation_matrix: self-checking bench of the rotation matrix
// Drives axis-angle beats from a queue, predicts each Rodrigues matrix in
// 64-bit fixed point and compares every output beat in order, under phases
// of random source gaps and sink stalls, with one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_axis_angle_rotation_matrix;

  typedef struct packed {
    logic [15:0] az;
    logic [15:0] ay;
    logic [15:0] ax;
    logic [15:0] ang;
  } axang_t;

  typedef struct {
    logic [15:0] r [9];
    logic        zero_axis;
  } matrix_t;

  localparam int MAX_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;
  logic         out_tuser;
  logic         acc_q;

  axang_t  pending_q[$];
  matrix_t expected_q[$];
  int      errors = 0;
  int      cycles = 0;
  int      src_idle_pct = 0;
  int      snk_stall_pct = 0;
  int      hold_off = 0;

  axis_angle_rotation_matrix DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint fshift(longint v, int n);
    return v >>> n;  // arithmetic shift is floor division
  endfunction

  function automatic longint qmul(longint p, longint q);
    return fshift(p * q + (64'sd1 <<< 29), 30);
  endfunction

  function automatic logic [15:0] to_q14(longint v);
    longint o;
    o = fshift(v + (64'sd1 <<< 15), 16);
    if (o > 16384) o = 16384;
    if (o < -16384) o = -16384;
    return o[15:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void sine_cosine(longint ang, output longint so, output longint co);
    longint a, q, r, u, x, x2, h, s, c, sr, cr;
    longint unsigned num;
    a = ang % 23040;
    if (a < 0) a += 23040;
    q = a / 5760;
    r = a % 5760;
    u = (r > 2880) ? 5760 - r : r;
    num = ((longint'(u) * 64'd31415926) << 27) + 64'd7200000000;
    x = num / 64'd14400000000;
    x2 = qmul(x, x);
    h = 2959;
    h = -213045 + qmul(x2, h);
    h = 8947849 + qmul(x2, h);
    h = -178956971 + qmul(x2, h);
    h = (64'sd1 <<< 30) + qmul(x2, h);
    s = qmul(x, h);
    h = -296;
    h = 26631 + qmul(x2, h);
    h = -1491308 + qmul(x2, h);
    h = 44739243 + qmul(x2, h);
    h = -(64'sd1 <<< 29) + qmul(x2, h);
    c = (64'sd1 <<< 30) + qmul(x2, h);
    if (r > 2880) begin
      sr = c; cr = s;
    end else begin
      sr = s; cr = c;
    end
    case (q)
      0: begin so = sr; co = cr; end
      1: begin so = cr; co = -sr; end
      2: begin so = -sr; co = -cr; end
      default: begin so = -cr; co = sr; end
    endcase
  endfunction

  function automatic matrix_t rotation_of(axang_t it);
    matrix_t m;
    longint v[3], a[3], s, c, t, pxy, pxz, pyz, mm;
    longint unsigned n2, len, mag;
    int k;
    v[0] = longint'($signed(it.ax));
    v[1] = longint'($signed(it.ay));
    v[2] = longint'($signed(it.az));
    n2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    m.zero_axis = (n2 == 0);
    k = 0;
    if (n2 == 0) begin
      a[0] = 0; a[1] = 0; a[2] = 0;
    end else begin
      while (n2 < (64'd1 << 62)) begin
        n2 <<= 2;
        k++;
      end
      len = int_sqrt(n2);
      for (int i = 0; i < 3; i++) begin
        mag = (v[i] < 0) ? -v[i] : v[i];
        mm = ((mag << (30 + k)) + len / 2) / len;
        a[i] = (v[i] < 0) ? -mm : mm;
      end
    end
    sine_cosine(longint'($signed(it.ang)), s, c);
    t = (64'sd1 <<< 30) - c;
    pxy = qmul(t, qmul(a[0], a[1]));
    pxz = qmul(t, qmul(a[0], a[2]));
    pyz = qmul(t, qmul(a[1], a[2]));
    m.r[0] = to_q14(c + qmul(t, qmul(a[0], a[0])));
    m.r[1] = to_q14(pxy - qmul(s, a[2]));
    m.r[2] = to_q14(pxz + qmul(s, a[1]));
    m.r[3] = to_q14(pxy + qmul(s, a[2]));
    m.r[4] = to_q14(c + qmul(t, qmul(a[1], a[1])));
    m.r[5] = to_q14(pyz - qmul(s, a[0]));
    m.r[6] = to_q14(pxz - qmul(s, a[1]));
    m.r[7] = to_q14(pyz + qmul(s, a[0]));
    m.r[8] = to_q14(c + qmul(t, qmul(a[2], a[2])));
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  task automatic push_item(int ang, int x, int y, int z);
    axang_t it;
    it.ang = ang[15:0];
    it.ax = x[15:0];
    it.ay = y[15:0];
    it.az = z[15:0];
    pending_q.push_back(it);
  endtask

  function automatic int rand_axis();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(0, 1) ? -32768 : 32767;
      2: return $signed(16'($urandom_range(0, 65535))) >>> $urandom_range(0, 14);
      default: return $signed(16'($urandom_range(0, 65535)));
    endcase
  endfunction

  function automatic int rand_angle();
    case ($urandom_range(0, 7))
      0: return 32'($urandom_range(0, 8)) * 2880 - 11520;
      1: return $signed(16'($urandom_range(0, 65535)));
      default: return $urandom_range(0, 46080) - 23040;
    endcase
  endfunction

  task automatic wait_drain();
    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0)
      @(posedge clk);
  endtask

  // acceptance as seen at the rising edge
  always @(posedge clk) acc_q <= in_tvalid && in_tready;

  // driver: offers the head of the queue, changes at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (acc_q) begin
        expected_q.push_back(rotation_of(axang_t'(in_tdata)));
        void'(pending_q.pop_front());
      end
      if ((!in_tvalid || acc_q) && pending_q.size() != 0 &&
          $urandom_range(0, 99) >= src_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_q[0];
      end else if (!in_tvalid || acc_q) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_tready <= rst_n && ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    matrix_t want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = expected_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (out_tdata[16*i +: 16] !== want.r[i])
            report_mismatch($sformatf("r%0d%0d", i / 3, i % 3),
                            $signed(out_tdata[16*i +: 16]), $signed(want.r[i]));
        if (out_tuser !== want.zero_axis)
          report_mismatch("zero_axis", out_tuser, want.zero_axis);
      end
    end
    if (cycles >= MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int extremes[4];
    extremes = '{-32768, 32767, 0, -1};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: angle extremes, wraps, quadrant and octant edges, zero and extreme axes
    push_item(0, 16384, 0, 0);
    push_item(23040, 0, 16384, 0);
    push_item(-23040, 0, 0, 16384);
    push_item(32767, 100, -200, 300);
    push_item(-32768, -32768, -32768, -32768);
    push_item(5760, 0, 0, 0);
    push_item(-5760, 0, 0, 0);
    push_item(11520, 32767, 32767, 32767);
    push_item(2880, 1, 0, 0);
    push_item(2881, 0, -1, 0);
    push_item(8641, -32768, 0, 0);
    push_item(17280, 32767, -32768, 1);
    foreach (extremes[i]) push_item(4000, extremes[i], extremes[3 - i], extremes[i]);
    push_item(1234, 11585, 11585, 0);
    push_item(-7000, 0, 0, -1);
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 56 : 23) : 0;
      snk_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 56 : 23) : 0;
      if (ph == 0) hold_off = 200;
      for (int n = 0; n < 375; n++)
        push_item(rand_angle(), rand_axis(), rand_axis(), rand_axis());
      wait_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* axis_angle_rotation_matrix.f */
rtl/aar_pkg.sv
rtl/axis_angle_rotation_matrix.sv
test/tb_axis_angle_rotation_matrix.sv
